// ===== rtl/core/erd_pkg.sv =====
// Package for the event record deframer: result item type, kind and status
// codes, header layout and register reset value. No dependencies.
package erd_pkg;

  // Input opcodes
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // End status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FAIL_HDR   = 3'd1;
  localparam logic [2:0] ST_TRUNC_TICK = 3'd2;
  localparam logic [2:0] ST_TRUNC_TIE  = 3'd3;
  localparam logic [2:0] ST_TRUNC_TYPE = 3'd4;
  localparam logic [2:0] ST_TRUNC_LEN  = 3'd5;
  localparam logic [2:0] ST_OVER_LEN   = 3'd6;
  localparam logic [2:0] ST_TRUNC_PAY  = 3'd7;

  // Header byte layout (24-byte little-endian header)
  localparam logic [4:0] TIE_START  = 5'd8;
  localparam logic [4:0] TYPE_START = 5'd16;
  localparam logic [4:0] LEN_START  = 5'd20;
  localparam logic [4:0] HDR_LAST   = 5'd23;

  localparam logic [31:0] MAX_LEN_RESET = 32'h0001_0000;

  // One result item as carried through the queue
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [63:0] tick;
    logic [63:0] tie_order;
    logic [31:0] event_type;
    logic [31:0] payload_length;
    logic [7:0]  payload_value;
    logic        record_end;
    logic [2:0]  status;
    logic [31:0] record_count;
  } erd_result_t;

  // Queue status seen by the back part and the top level
  typedef struct packed {
    logic full;
    logic empty;
  } erd_qstat_t;

endpackage

// ===== rtl/core/event_record_deframer.sv =====
// Top level of the event record deframer: front parser, result queue and
// output channel. Depends on erd_pkg, erd_front and erd_back.
//
// Parses a byte stream of records (24-byte little-endian header, then
// payload) at one item per cycle: every data byte or end-of-stream item is
// classified and turned into at most one result in the cycle it is
// accepted, and results drain from a QUEUE_DEPTH-entry queue at one per
// cycle while out_stall is low. in_stall rises only while the queue is full,
// so throughput is one item per cycle unless the output side stalls. Header
// bytes produce no result until the 24th, which emits the header (or latches
// the over-length error); an end-of-stream item emits the status and record
// count and starts a new stream. max_payload_length may be written at any
// time the block is idle; cfg_ready is always high.
module event_record_deframer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [63:0] out_tick,
  output logic [63:0] out_tie_order,
  output logic [31:0] out_event_type,
  output logic [31:0] out_payload_length,
  output logic [7:0]  out_payload_value,
  output logic        out_record_end,
  output logic [2:0]  out_status,
  output logic [31:0] out_record_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import erd_pkg::*;

  logic        in_acc;
  logic        push;
  erd_result_t push_item;
  erd_result_t head;
  erd_qstat_t  qstat;

  assign in_stall  = qstat.full;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Parser
  erd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .opcode    (in_opcode),
    .data_byte (in_data_byte),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (push_item)
  );

  // Result queue
  erd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .qstat     (qstat)
  );

  // Output fields
  assign out_result_kind    = head.result_kind;
  assign out_tick           = head.tick;
  assign out_tie_order      = head.tie_order;
  assign out_event_type     = head.event_type;
  assign out_payload_length = head.payload_length;
  assign out_payload_value  = head.payload_value;
  assign out_record_end     = head.record_end;
  assign out_status         = head.status;
  assign out_record_count   = head.record_count;

`ifndef ASSERT_OFF
  // every accepted end of stream yields a result
  a_eos_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_opcode == OP_EOS |-> push)
    else $error("end of stream produced no result");

  // the parser never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("result queue overflow");

  // status items never carry a record end mark
  a_status_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_STATUS |-> !out_record_end)
    else $error("record end set on status item");

  // payload items carry no status or count
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_PAYLOAD |->
      out_status == ST_OK && out_record_count == 32'd0)
    else $error("payload item carries status fields");
`endif

endmodule

// ===== rtl/core/erd_front.sv =====
// Front part of the deframer: accepts stream items, assembles headers,
// tracks payload and stream status, and builds result items. Uses erd_pkg.
module erd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic                opcode,
  input  logic [7:0]          data_byte,
  input  logic                cfg_wr,
  input  logic [31:0]         cfg_data,
  output logic                push,
  output erd_pkg::erd_result_t item
);
  import erd_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_ERROR   = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [63:0] tick_r, tick_nxt;
  logic [63:0] tie_r, tie_nxt;
  logic [31:0] type_r, type_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] max_len_r, max_len_nxt;
  logic [31:0] full_len;
  logic [31:0] count_inc;
  logic [2:0]  end_st;

  assign full_len  = {data_byte, len_r[23:0]};
  assign count_inc = (count_r == '1) ? count_r : count_r + 32'd1;

  // Final status at end of stream
  always_comb begin
    priority if (phase_r == PH_ERROR) begin
      end_st = err_r;
    end else if (phase_r == PH_PAYLOAD) begin
      end_st = ST_TRUNC_PAY;
    end else if (idx_r == 5'd0) begin
      end_st = ST_OK;
    end else if (idx_r < TIE_START) begin
      end_st = (count_r == 32'd0) ? ST_FAIL_HDR : ST_TRUNC_TICK;
    end else if (idx_r < TYPE_START) begin
      end_st = ST_TRUNC_TIE;
    end else if (idx_r < LEN_START) begin
      end_st = ST_TRUNC_TYPE;
    end else begin
      end_st = ST_TRUNC_LEN;
    end
  end

  // Parser next state and result item
  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    tick_nxt    = tick_r;
    tie_nxt     = tie_r;
    type_nxt    = type_r;
    len_nxt     = len_r;
    remain_nxt  = remain_r;
    err_nxt     = err_r;
    count_nxt   = count_r;
    max_len_nxt = cfg_wr ? cfg_data : max_len_r;
    push        = 1'b0;
    item        = '0;
    if (acc) begin
      if (opcode == OP_EOS) begin
        push              = 1'b1;
        item.result_kind  = KIND_STATUS;
        item.status       = end_st;
        item.record_count = count_r;
        phase_nxt  = PH_HEADER;
        idx_nxt    = 5'd0;
        tick_nxt   = '0;
        tie_nxt    = '0;
        type_nxt   = '0;
        len_nxt    = '0;
        remain_nxt = '0;
        err_nxt    = ST_OK;
        count_nxt  = '0;
      end else begin
        unique case (phase_r)
          PH_PAYLOAD: begin
            push               = 1'b1;
            item.result_kind   = KIND_PAYLOAD;
            item.payload_value = data_byte;
            remain_nxt         = remain_r - 32'd1;
            if (remain_r == 32'd1) begin
              item.record_end = 1'b1;
              count_nxt       = count_inc;
              phase_nxt       = PH_HEADER;
            end
          end
          PH_HEADER: begin
            // place the byte in its field lane
            priority if (idx_r < TIE_START) begin
              tick_nxt[{idx_r[2:0], 3'b000} +: 8] = data_byte;
            end else if (idx_r < TYPE_START) begin
              tie_nxt[{idx_r[2:0], 3'b000} +: 8] = data_byte;
            end else if (idx_r < LEN_START) begin
              type_nxt[{idx_r[1:0], 3'b000} +: 8] = data_byte;
            end else begin
              len_nxt[{idx_r[1:0], 3'b000} +: 8] = data_byte;
            end
            if (idx_r == HDR_LAST) begin
              idx_nxt = 5'd0;
              if (full_len > max_len_r) begin
                phase_nxt = PH_ERROR;
                err_nxt   = ST_OVER_LEN;
              end else begin
                push                = 1'b1;
                item.result_kind    = KIND_HEADER;
                item.tick           = tick_r;
                item.tie_order      = tie_r;
                item.event_type     = type_r;
                item.payload_length = full_len;
                tick_nxt = '0;
                tie_nxt  = '0;
                type_nxt = '0;
                len_nxt  = '0;
                if (full_len == 32'd0) begin
                  item.record_end = 1'b1;
                  count_nxt       = count_inc;
                end else begin
                  remain_nxt = full_len;
                  phase_nxt  = PH_PAYLOAD;
                end
              end
            end else begin
              idx_nxt = idx_r + 5'd1;
            end
          end
          default: begin
            // error latched: data bytes are dropped
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      idx_r     <= 5'd0;
      tick_r    <= '0;
      tie_r     <= '0;
      type_r    <= '0;
      len_r     <= '0;
      remain_r  <= '0;
      err_r     <= ST_OK;
      count_r   <= '0;
      max_len_r <= MAX_LEN_RESET;
    end else begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      tick_r    <= tick_nxt;
      tie_r     <= tie_nxt;
      type_r    <= type_nxt;
      len_r     <= len_nxt;
      remain_r  <= remain_nxt;
      err_r     <= err_nxt;
      count_r   <= count_nxt;
      max_len_r <= max_len_nxt;
    end
  end

endmodule

// ===== rtl/core/erd_back.sv =====
// Back part of the deframer: a short queue of result items that presents
// the oldest one on the output channel. Uses erd_pkg.
module erd_back #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  erd_pkg::erd_result_t push_item,
  input  logic                out_stall,
  output logic                out_valid,
  output erd_pkg::erd_result_t head,
  output erd_pkg::erd_qstat_t qstat
);
  import erd_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);

  erd_result_t   q_mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign qstat.full  = (cnt_r == DEPTH_C);
  assign qstat.empty = (cnt_r == '0);
  assign out_valid   = !qstat.empty;
  assign head        = q_mem[rd_ptr_r];
  assign pop         = out_valid && !out_stall;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_item;
    end
  end

endmodule
